// ----- rtl/mhtq_pkg.sv -----
// ----------------------------------------------------------------------------
// Timer queue package
// Shared types, constants and command structures for the timer queue.
// ----------------------------------------------------------------------------
package mhtq_pkg;

  localparam int unsigned Capacity = 32;
  localparam int unsigned IdCount  = 1024;
  localparam int unsigned SlotW    = $clog2(Capacity);
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned IdW      = 10;
  localparam int unsigned TmoW     = 31;
  localparam int unsigned ElW      = 16;
  localparam int unsigned TimeW    = 32;

  typedef enum logic [2:0] {
    FUNC_ADD     = 3'd0,
    FUNC_ADJUST  = 3'd1,
    FUNC_FIRE    = 3'd2,
    FUNC_ADVANCE = 3'd3,
    FUNC_CLEAR   = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    KIND_EXPIRED = 2'd0,
    KIND_REPORT  = 2'd1,
    KIND_ACK     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_FULL    = 2'd1,
    ERR_UNKNOWN = 2'd2
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DECIDE,
    ST_HEAD,
    ST_REM_SWAP,
    ST_SINK_RD,
    ST_SINK_CMP,
    ST_RISE_RD,
    ST_RISE_CMP,
    ST_EMIT,
    ST_WAIT
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       load;       // capture input word
    logic       look;       // read slot map for id
    logic       write_new;  // append new entry at count
    logic       write_dl;   // write new deadline at slot
    logic       advance;    // add elapsed time to now
    logic       clear;      // zero the count
    logic       rem_swap;   // move last entry into cursor, shrink count
    logic       sink_rd;    // read cursor and children
    logic       sink_swap;  // swap cursor with chosen child
    logic       rise_rd;    // read cursor and parent
    logic       rise_swap;  // swap cursor with parent
    logic       head;       // point cursor at root
    logic       emit;       // load output register
    logic [1:0] okind;
    logic [1:0] oerr;
    logic       olast;
  } mhtq_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [2:0] func;
    logic       found;
    logic       full;
    logic       empty;
    logic       cur_is_last;
    logic       cur_is_root;
    logic       sink_go;
    logic       rise_go;
    logic       moved;
    logic       head_due;
    logic       out_busy;
  } mhtq_sts_t;

endpackage

// ----- rtl/mhtq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Timer queue controller
// Sequences lookup, insert, removal, sift-down and sift-up as each command requires.
// ----------------------------------------------------------------------------
module mhtq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mhtq_pkg::mhtq_sts_t sts_i,
  output mhtq_pkg::mhtq_cmd_t cmd_o
);
  import mhtq_pkg::*;

  state_e state_q, state_d;
  logic   adv_q, adv_d;
  logic   rem_q, rem_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      adv_q   <= 1'b0;
      rem_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      adv_q   <= adv_d;
      rem_q   <= rem_d;
    end
  end

  always_comb begin
    state_d = state_q;
    adv_d   = adv_q;
    rem_d   = rem_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        adv_d = 1'b0;
        rem_d = 1'b0;
        if (sts_i.out_busy) begin
          state_d = ST_DECIDE;
        end else begin
          unique case (sts_i.func)
            FUNC_ADD: begin
              if (sts_i.found) begin
                state_d = ST_SINK_RD;
              end else if (sts_i.full) begin
                state_d = ST_IDLE;
              end else begin
                state_d = ST_RISE_RD;
              end
            end
            FUNC_ADJUST: begin
              if (sts_i.found) begin
                state_d = ST_SINK_RD;
              end else begin
                state_d = ST_IDLE;
              end
            end
            FUNC_FIRE: begin
              if (sts_i.found) begin
                rem_d   = 1'b1;
                state_d = ST_REM_SWAP;
              end else begin
                state_d = ST_IDLE;
              end
            end
            FUNC_ADVANCE: begin
              adv_d   = 1'b1;
              state_d = ST_HEAD;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_HEAD: begin
        if (!sts_i.out_busy) begin
          if (!sts_i.empty && sts_i.head_due) begin
            state_d = ST_REM_SWAP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_REM_SWAP: begin
        state_d = sts_i.cur_is_last ? ST_EMIT : ST_SINK_RD;
      end
      ST_SINK_RD: begin
        state_d = ST_SINK_CMP;
      end
      ST_SINK_CMP: begin
        if (sts_i.sink_go) begin
          state_d = ST_SINK_RD;
        end else if (sts_i.moved) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_RISE_RD;
        end
      end
      ST_RISE_RD: begin
        state_d = sts_i.cur_is_root ? ST_EMIT : ST_RISE_CMP;
      end
      ST_RISE_CMP: begin
        state_d = sts_i.rise_go ? ST_RISE_RD : ST_EMIT;
      end
      ST_EMIT: begin
        if (adv_q) begin
          state_d = ST_HEAD;
        end else if (!sts_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_LOOK: begin
        cmd_o.look = 1'b1;
      end
      ST_DECIDE: begin
        if (!sts_i.out_busy) begin
          unique case (sts_i.func)
            FUNC_ADD: begin
              cmd_o.okind = KIND_ACK;
              cmd_o.olast = 1'b1;
              if (sts_i.found) begin
                cmd_o.write_dl = 1'b1;
              end else if (sts_i.full) begin
                cmd_o.oerr = ERR_FULL;
                cmd_o.emit = 1'b1;
              end else begin
                cmd_o.write_new = 1'b1;
              end
            end
            FUNC_ADJUST: begin
              cmd_o.okind = KIND_ACK;
              cmd_o.olast = 1'b1;
              if (sts_i.found) begin
                cmd_o.write_dl = 1'b1;
              end else begin
                cmd_o.oerr = ERR_UNKNOWN;
                cmd_o.emit = 1'b1;
              end
            end
            FUNC_FIRE: begin
              if (sts_i.found) begin
                cmd_o.emit = 1'b0;
              end else begin
                cmd_o.okind = KIND_ACK;
                cmd_o.oerr  = ERR_UNKNOWN;
                cmd_o.olast = 1'b1;
                cmd_o.emit  = 1'b1;
              end
            end
            FUNC_ADVANCE: begin
              cmd_o.advance = 1'b1;
            end
            FUNC_CLEAR: begin
              cmd_o.clear = 1'b1;
              cmd_o.okind = KIND_ACK;
              cmd_o.olast = 1'b1;
              cmd_o.emit  = 1'b1;
            end
            default: begin
              cmd_o.okind = KIND_ACK;
              cmd_o.olast = 1'b1;
              cmd_o.emit  = 1'b1;
            end
          endcase
        end
      end
      ST_HEAD: begin
        cmd_o.head = 1'b1;
        if (!sts_i.out_busy && !(!sts_i.empty && sts_i.head_due)) begin
          cmd_o.okind = KIND_REPORT;
          cmd_o.olast = 1'b1;
          cmd_o.emit  = 1'b1;
        end
      end
      ST_REM_SWAP: cmd_o.rem_swap = 1'b1;
      ST_SINK_RD:  cmd_o.sink_rd = 1'b1;
      ST_SINK_CMP: cmd_o.sink_swap = sts_i.sink_go;
      ST_RISE_RD:  cmd_o.rise_rd = 1'b1;
      ST_RISE_CMP: cmd_o.rise_swap = sts_i.rise_go;
      ST_EMIT: begin
        if (!adv_q && !sts_i.out_busy) begin
          cmd_o.emit  = 1'b1;
          cmd_o.okind = rem_q ? KIND_EXPIRED : KIND_ACK;
          cmd_o.olast = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/mhtq_dpath.sv -----
// ----------------------------------------------------------------------------
// Timer queue datapath
// Heap memories, slot map, clock register, cursor and output word register.
// ----------------------------------------------------------------------------
module mhtq_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [2:0]                  func_i,
  input  logic [mhtq_pkg::IdW-1:0]    timer_id_i,
  input  logic [mhtq_pkg::TmoW-1:0]   timeout_ms_i,
  input  logic [mhtq_pkg::ElW-1:0]    elapsed_ms_i,
  input  mhtq_pkg::mhtq_cmd_t         cmd_i,
  output mhtq_pkg::mhtq_sts_t         sts_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  kind_o,
  output logic [mhtq_pkg::IdW-1:0]    out_id_o,
  output logic [mhtq_pkg::TmoW-1:0]   remaining_ms_o,
  output logic                        queue_empty_o,
  output logic [1:0]                  error_o,
  output logic                        last_o
);
  import mhtq_pkg::*;

  logic [IdW-1:0]   ids_q [Capacity];
  logic [TimeW-1:0] dls_q [Capacity];
  logic [SlotW-1:0] map_q [IdCount];

  logic [2:0]       func_q;
  logic [IdW-1:0]   id_q;
  logic [TmoW-1:0]  tmo_q;
  logic [ElW-1:0]   el_q;
  logic [CountW-1:0] count_q;
  logic [TimeW-1:0] now_q;
  logic [SlotW-1:0] cur_q, start_q, map_rd_q;
  logic [IdW-1:0]   fired_q;

  logic [TimeW-1:0] c_dl_q, l_dl_q, r_dl_q, p_dl_q;
  logic             l_ok_q, r_ok_q;

  logic             ov_q;
  logic [1:0]       okind_q, oerr_q;
  logic [IdW-1:0]   oid_q;
  logic [TmoW-1:0]  orem_q;
  logic             oempty_q, olast_q;

  logic [CountW:0]  l_idx, r_idx;
  logic [SlotW-1:0] par, last_slot, child;
  logic [TimeW-1:0] new_dl, head_diff;
  logic             pick_r, head_due, found;
  logic [CountW-1:0] count_n;

  assign l_idx     = {cur_q, 1'b1};
  assign r_idx     = l_idx + (CountW+1)'(1);
  assign par       = SlotW'((cur_q - SlotW'(1)) >> 1);
  assign last_slot = SlotW'(count_q - CountW'(1));
  assign pick_r    = r_ok_q && (r_dl_q < l_dl_q);
  assign child     = pick_r ? SlotW'(r_idx) : SlotW'(l_idx);
  assign new_dl    = now_q + {1'b0, tmo_q};
  assign head_diff = dls_q[0] - now_q;
  assign head_due  = (head_diff == '0) || head_diff[TimeW-1];
  assign found     = (CountW'(map_rd_q) < count_q) && (ids_q[map_rd_q] == id_q);
  assign count_n   = count_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      id_q   <= timer_id_i;
      tmo_q  <= timeout_ms_i;
      el_q   <= elapsed_ms_i;
    end
    if (cmd_i.look) begin
      map_rd_q <= map_q[id_q];
    end
    if (cmd_i.write_dl) begin
      dls_q[map_rd_q] <= new_dl;
      cur_q   <= map_rd_q;
      start_q <= map_rd_q;
    end
    if (cmd_i.write_new) begin
      ids_q[SlotW'(count_q)] <= id_q;
      dls_q[SlotW'(count_q)] <= new_dl;
      map_q[id_q]            <= SlotW'(count_q);
      cur_q   <= SlotW'(count_q);
      start_q <= SlotW'(count_q);
    end
    if (cmd_i.head) begin
      cur_q   <= '0;
      fired_q <= ids_q[0];
    end
    if (!cmd_i.head && !cmd_i.write_dl && !cmd_i.write_new && cmd_i.look) begin
      cur_q   <= map_q[id_q];
    end
    if (cmd_i.rem_swap) begin
      start_q <= cur_q;
      if (cur_q != last_slot) begin
        ids_q[cur_q] <= ids_q[last_slot];
        dls_q[cur_q] <= dls_q[last_slot];
        map_q[ids_q[last_slot]] <= cur_q;
      end
    end
    if (cmd_i.sink_rd) begin
      c_dl_q <= dls_q[cur_q];
      l_ok_q <= l_idx < (CountW+1)'(count_q);
      r_ok_q <= r_idx < (CountW+1)'(count_q);
      l_dl_q <= dls_q[SlotW'(l_idx)];
      r_dl_q <= dls_q[SlotW'(r_idx)];
    end
    if (cmd_i.sink_swap) begin
      ids_q[cur_q] <= ids_q[child];
      dls_q[cur_q] <= dls_q[child];
      ids_q[child] <= ids_q[cur_q];
      dls_q[child] <= dls_q[cur_q];
      map_q[ids_q[child]] <= cur_q;
      map_q[ids_q[cur_q]] <= child;
      cur_q <= child;
    end
    if (cmd_i.rise_rd) begin
      c_dl_q <= dls_q[cur_q];
      p_dl_q <= dls_q[par];
    end
    if (cmd_i.rise_swap) begin
      ids_q[cur_q] <= ids_q[par];
      dls_q[cur_q] <= dls_q[par];
      ids_q[par]   <= ids_q[cur_q];
      dls_q[par]   <= dls_q[cur_q];
      map_q[ids_q[par]]   <= cur_q;
      map_q[ids_q[cur_q]] <= par;
      cur_q <= par;
    end
  end

  // The look step latches the map entry; cursor follows it for fire.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      now_q   <= '0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.write_new) begin
        count_q <= count_q + CountW'(1);
      end else if (cmd_i.rem_swap) begin
        count_q <= count_q - CountW'(1);
      end
      if (cmd_i.advance) begin
        now_q <= now_q + TimeW'(el_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ov_q <= 1'b1;
    end else if (cmd_i.rem_swap && func_q == FUNC_ADVANCE) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      okind_q  <= cmd_i.okind;
      oerr_q   <= cmd_i.oerr;
      olast_q  <= cmd_i.olast;
      oempty_q <= (count_q == '0) || (cmd_i.clear);
      if (cmd_i.okind == KIND_REPORT) begin
        oid_q  <= '0;
        orem_q <= (count_q != '0 && !head_due) ? TmoW'(head_diff) : '0;
      end else begin
        oid_q  <= id_q;
        orem_q <= '0;
      end
    end else if (cmd_i.rem_swap && func_q == FUNC_ADVANCE) begin
      okind_q  <= KIND_EXPIRED;
      oerr_q   <= ERR_OK;
      olast_q  <= 1'b0;
      oid_q    <= fired_q;
      orem_q   <= '0;
      oempty_q <= (count_q == CountW'(1));
    end
  end

  always_comb begin
    sts_o             = '0;
    sts_o.func        = func_q;
    sts_o.found       = found;
    sts_o.full        = count_n >= CountW'(Capacity);
    sts_o.empty       = count_q == '0;
    sts_o.cur_is_last = cur_q == last_slot;
    sts_o.cur_is_root = cur_q == '0;
    sts_o.sink_go     = l_ok_q && ((pick_r ? r_dl_q : l_dl_q) < c_dl_q);
    sts_o.rise_go     = p_dl_q > c_dl_q;
    sts_o.moved       = cur_q != start_q;
    sts_o.head_due    = head_due;
    sts_o.out_busy    = ov_q && !out_ready_i;
  end

  assign out_valid_o    = ov_q;
  assign kind_o         = okind_q;
  assign out_id_o       = oid_q;
  assign remaining_ms_o = orem_q;
  assign queue_empty_o  = oempty_q;
  assign error_o        = oerr_q;
  assign last_o         = olast_q;

endmodule

// ----- rtl/min_heap_timer_queue.sv -----
// ----------------------------------------------------------------------------
// Min-heap timer queue
// Channel  Dir  Fields (tdata low bit up)                         tuser
// s_axis   in   timer_id[9:0] timeout_ms[40:10] elapsed_ms[56:41]  func
// m_axis   out  out_id[9:0] remaining_ms[40:10] queue_empty[41]   kind,error
//                error via tuser[3:2], last as tlast
// An add or adjust runs lookup, decide and the sift loop before its output
// word; a fire also removes the entry first. A rejected command or a clear
// answers at decide; an advance emits each expired timer, then a report.
// A full output word stalls the sequencer until taken.
// Reset empties the queue and zeroes the clock; heap contents are stale.
// ----------------------------------------------------------------------------
module min_heap_timer_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // timer_id, timeout_ms, elapsed_ms
  input  logic [2:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_id, remaining_ms, queue_empty
  output logic [3:0]  m_axis_tuser,   // kind, error
  output logic        m_axis_tlast
);
  import mhtq_pkg::*;

  mhtq_cmd_t cmd;
  mhtq_sts_t sts;
  logic [1:0]      kind, err;
  logic [IdW-1:0]  oid;
  logic [TmoW-1:0] orem;
  logic            oempty;

  mhtq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mhtq_dpath u_dpath (
    .clk_i, .rst_ni,
    .func_i         (s_axis_tuser),
    .timer_id_i     (s_axis_tdata[9:0]),
    .timeout_ms_i   (s_axis_tdata[40:10]),
    .elapsed_ms_i   (s_axis_tdata[56:41]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .kind_o         (kind),
    .out_id_o       (oid),
    .remaining_ms_o (orem),
    .queue_empty_o  (oempty),
    .error_o        (err),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, oempty, orem, oid};
  assign m_axis_tuser = {err, kind};

  property p_ready_idle;
    @(posedge clk_i) disable iff (!rst_ni)
      (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready;
  endproperty
  assert property (p_ready_idle) else $error("input taken while busy");

  property p_report_no_err;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && m_axis_tuser[1:0] != KIND_ACK) |-> m_axis_tuser[3:2] == ERR_OK;
  endproperty
  assert property (p_report_no_err) else $error("error on non-ack word");

  property p_report_last;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && m_axis_tuser[1:0] == KIND_REPORT) |-> m_axis_tlast;
  endproperty
  assert property (p_report_last) else $error("report not last");

endmodule
